// ----- hw/rtl/wsd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    // Widest frame length that is not rejected outright.
    localparam int LENGTH_BITS = 64;
    localparam logic [63:0] LEN_LIMIT_MASK =
        (LENGTH_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LENGTH_BITS) - 64'd1);

    // Parser phases.
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_DATA       = 3'd0;
    localparam logic [2:0] ST_EMPTY      = 3'd1;
    localparam logic [2:0] ST_BAD_OPCODE = 3'd2;
    localparam logic [2:0] ST_TOO_LONG   = 3'd3;
    localparam logic [2:0] ST_FRAGMENTED = 3'd4;

    localparam logic [3:0] OPC_TEXT   = 4'd1;
    localparam logic [3:0] OPC_BINARY = 4'd2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1024;

    // Work queue between the parser and the output stage.
    localparam int QDEPTH  = 4;
    localparam int QADDR_W = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic [3:0] opcode;
        logic       last;
        logic [2:0] status;
    } wsd_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/websocket_frame_deframer_top.sv -----
// Top level of the WebSocket frame deframer.
`timescale 1ns / 1ps
`default_nettype none

// The deframer takes one received stream byte per cycle and gives one result word per
// payload byte, plus one word for each empty frame and each rejected header (bad opcode,
// length above max_payload, or FIN clear). The header parser handles every byte
// combinationally, so a new byte can be accepted each cycle; results pass through a
// four-word queue and an output register.
// Input is stalled only while that queue is full. Write max_payload only while idle.

module websocket_frame_deframer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        cfg_write_en,
    input  wire logic [31:0] cfg_write_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       payload_byte,
    output logic [3:0]       frame_opcode,
    output logic             is_last,
    output logic [2:0]       status
);
    import wsd_pkg::*;

    logic       accept;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    wsd_entry_t q_in;
    wsd_entry_t q_head;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    wsd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .rx_byte        (rx_byte),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .push           (q_push),
        .push_entry     (q_in)
    );

    wsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    wsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .empty        (q_empty),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .frame_opcode (frame_opcode),
        .is_last      (is_last),
        .status       (status)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job queued while queue full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job taken from empty queue");

    a_nondata_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DATA) |-> is_last)
        else $error("empty or error word without last marker");

    a_nondata_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DATA) |-> (payload_byte == 8'd0))
        else $error("empty or error word carries a payload byte");

endmodule

`default_nettype wire

// ----- hw/rtl/wsd_front.sv -----
// Header parser: accepts raw bytes, tracks frame state and queues one job per result.
`timescale 1ns / 1ps
`default_nettype none

module wsd_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          rx_byte,
    input  wire logic                cfg_write_en,
    input  wire logic [31:0]         cfg_write_data,
    output logic                     push,
    output wsd_pkg::wsd_entry_t      push_entry
);
    import wsd_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  hcount_reg, hcount_next;
    logic [63:0] flen_reg, flen_next;
    logic [31:0] remain_reg, remain_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] key_reg, key_next;
    logic        maskp_reg, maskp_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opc_reg, opc_next;
    logic [31:0] max_payload_reg;

    logic        len_done;
    logic        hdr_done;
    logic [63:0] len_val;
    logic        too_long;
    logic [7:0]  key_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR0;
            hcount_reg      <= '0;
            flen_reg        <= '0;
            remain_reg      <= '0;
            idx_reg         <= '0;
            key_reg         <= '0;
            maskp_reg       <= 1'b0;
            fin_reg         <= 1'b0;
            opc_reg         <= '0;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            flen_reg   <= flen_next;
            remain_reg <= remain_next;
            idx_reg    <= idx_next;
            key_reg    <= key_next;
            maskp_reg  <= maskp_next;
            fin_reg    <= fin_next;
            opc_reg    <= opc_next;
            if (cfg_write_en)
            begin
                max_payload_reg <= cfg_write_data;
            end
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        flen_next   = flen_reg;
        remain_next = remain_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        maskp_next  = maskp_reg;
        fin_next    = fin_reg;
        opc_next    = opc_reg;
        push        = 1'b0;
        push_entry  = '{data: 8'd0, key: 8'd0, opcode: opc_reg, last: 1'b1,
                        status: ST_DATA};
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        len_val     = flen_reg;
        too_long    = 1'b0;

        if (accept)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    maskp_next = rx_byte[7];
                    key_next   = '0;
                    flen_next  = '0;
                    if (rx_byte[6:0] == LEN7_EXT16)
                    begin
                        phase_next  = PH_EXTLEN;
                        hcount_next = 4'd2;
                    end
                    else if (rx_byte[6:0] == LEN7_EXT64)
                    begin
                        phase_next  = PH_EXTLEN;
                        hcount_next = 4'd8;
                    end
                    else
                    begin
                        flen_next = {57'd0, rx_byte[6:0]};
                        len_val   = flen_next;
                        len_done  = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    flen_next   = {flen_reg[55:0], rx_byte};
                    len_val     = flen_next;
                    hcount_next = hcount_reg - 4'd1;
                    len_done    = (hcount_next == 4'd0);
                end
                PH_MASK:
                begin
                    key_next    = {key_reg[23:0], rx_byte};
                    hcount_next = hcount_reg - 4'd1;
                    hdr_done    = (hcount_next == 4'd0);
                end
                PH_PAYLOAD:
                begin
                    push            = 1'b1;
                    push_entry.data = rx_byte;
                    push_entry.key  = maskp_reg ? key_byte : 8'd0;
                    push_entry.last = (remain_reg == 32'd1);
                    idx_next        = idx_reg + 2'd1;
                    remain_next     = remain_reg - 32'd1;
                    if (remain_reg == 32'd1)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    fin_next = rx_byte[7];
                    opc_next = rx_byte[3:0];
                    if (rx_byte[3:0] inside {OPC_TEXT, OPC_BINARY})
                    begin
                        phase_next = PH_HDR1;
                    end
                    else
                    begin
                        push              = 1'b1;
                        push_entry.opcode = rx_byte[3:0];
                        push_entry.status = ST_BAD_OPCODE;
                        phase_next        = PH_HDR0;
                        hcount_next       = '0;
                    end
                end
            endcase

            // The length is complete: check it against the max_payload limit.
            if (len_done)
            begin
                too_long = ((len_val & ~LEN_LIMIT_MASK) != 64'd0) ||
                           (len_val[63:32] != 32'd0) ||
                           (len_val[31:0] > max_payload_reg);
                if (too_long)
                begin
                    push              = 1'b1;
                    push_entry.status = ST_TOO_LONG;
                    phase_next        = PH_HDR0;
                    hcount_next       = '0;
                end
                else if (maskp_next)
                begin
                    phase_next  = PH_MASK;
                    hcount_next = 4'd4;
                    key_next    = '0;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            // Header fully read: check FIN, then either finish or start payload.
            if (hdr_done)
            begin
                if (!fin_reg)
                begin
                    push              = 1'b1;
                    push_entry.status = ST_FRAGMENTED;
                    phase_next        = PH_HDR0;
                    hcount_next       = '0;
                end
                else if (len_val == 64'd0)
                begin
                    push              = 1'b1;
                    push_entry.status = ST_EMPTY;
                    phase_next        = PH_HDR0;
                    hcount_next       = '0;
                end
                else
                begin
                    phase_next  = PH_PAYLOAD;
                    remain_next = len_val[31:0];
                    idx_next    = '0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/wsd_queue.sv -----
// Short job queue between the header parser and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module wsd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire wsd_pkg::wsd_entry_t push_entry,
    input  wire logic                pop,
    output wsd_pkg::wsd_entry_t      head,
    output logic                     full,
    output logic                     empty
);
    import wsd_pkg::*;

    wsd_entry_t         mem [QDEPTH];
    logic [QADDR_W-1:0] wr_ptr_reg;
    logic [QADDR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QADDR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QADDR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/wsd_back.sv -----
// Output stage: unmasks queued payload bytes and holds each result word until taken.
`timescale 1ns / 1ps
`default_nettype none

module wsd_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wsd_pkg::wsd_entry_t head,
    input  wire logic                empty,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [7:0]               payload_byte,
    output logic [3:0]               frame_opcode,
    output logic                     is_last,
    output logic [2:0]               status
);
    import wsd_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [3:0] opc_reg;
    logic       last_reg;
    logic [2:0] status_reg;

    // The output register reloads when it is empty or its word leaves this cycle.
    assign pop = !empty && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || !out_stall)
        begin
            valid_reg <= !empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg   <= head.data ^ head.key;
            opc_reg    <= head.opcode;
            last_reg   <= head.last;
            status_reg <= head.status;
        end
    end

    assign out_valid    = valid_reg;
    assign payload_byte = byte_reg;
    assign frame_opcode = opc_reg;
    assign is_last      = last_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the WebSocket frame deframer top level.
`timescale 1ns / 1ps

module testbench;
    import wsd_pkg::*;

    localparam int RANDOM_WORDS  = 550;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_LIMIT   = 100;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] opcode;
        logic       last;
        logic [2:0] status;
    } result_word_t;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;
    typedef enum {LEN_FORM_7, LEN_FORM_16, LEN_FORM_64} len_form_e;

    // Tracks the parser state word by word and holds the result words still owed.
    class deframe_scoreboard;
        logic [31:0]  max_len;
        logic [2:0]   ph;
        logic [3:0]   hdr_left;
        logic [63:0]  frame_len;
        logic [63:0]  pay_idx;
        logic [31:0]  mask_key;
        logic         masked;
        logic         fin;
        logic [3:0]   opcode;
        result_word_t expected_words [$];
        int           errors;

        function new();
            max_len   = MAX_PAYLOAD_RESET;
            ph        = PH_HDR0;
            hdr_left  = '0;
            frame_len = '0;
            pay_idx   = '0;
            mask_key  = '0;
            masked    = 1'b0;
            fin       = 1'b0;
            opcode    = '0;
            errors    = 0;
        endfunction

        function void set_limit(logic [31:0] value);
            max_len = value;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void push_word(logic [7:0] data, logic [3:0] opc, logic last,
                                logic [2:0] st);
            expected_words.push_back({data, opc, last, st});
        endfunction

        function void restart_frame(logic [2:0] st);
            ph       = PH_HDR0;
            hdr_left = '0;
            push_word(8'd0, opcode, 1'b1, st);
        endfunction

        function void header_complete();
            if (!fin)
                restart_frame(ST_FRAGMENTED);
            else if (frame_len == 64'd0)
                restart_frame(ST_EMPTY);
            else
            begin
                ph      = PH_PAYLOAD;
                pay_idx = '0;
            end
        endfunction

        function void length_complete();
            if ((frame_len & ~LEN_LIMIT_MASK) != 64'd0 || frame_len > {32'd0, max_len})
                restart_frame(ST_TOO_LONG);
            else if (masked)
            begin
                ph       = PH_MASK;
                hdr_left = 4'd4;
                mask_key = '0;
            end
            else
                header_complete();
        endfunction

        function void note_rx_word(logic [7:0] w);
            logic [7:0] kb;
            logic       last;
            case (ph)
                PH_HDR1:
                begin
                    masked    = w[7];
                    mask_key  = '0;
                    frame_len = '0;
                    if (w[6:0] == LEN7_EXT16)
                    begin
                        ph       = PH_EXTLEN;
                        hdr_left = 4'd2;
                    end
                    else if (w[6:0] == LEN7_EXT64)
                    begin
                        ph       = PH_EXTLEN;
                        hdr_left = 4'd8;
                    end
                    else
                    begin
                        frame_len = {57'd0, w[6:0]};
                        length_complete();
                    end
                end
                PH_EXTLEN:
                begin
                    frame_len = {frame_len[55:0], w};
                    hdr_left--;
                    if (hdr_left == 4'd0)
                        length_complete();
                end
                PH_MASK:
                begin
                    mask_key = {mask_key[23:0], w};
                    hdr_left--;
                    if (hdr_left == 4'd0)
                        header_complete();
                end
                PH_PAYLOAD:
                begin
                    // The first key word sits in the top bits and is used on index 0 mod 4.
                    kb = masked ? mask_key[8 * (3 - pay_idx[1:0]) +: 8] : 8'd0;
                    pay_idx++;
                    last = (pay_idx >= frame_len);
                    if (last)
                    begin
                        ph      = PH_HDR0;
                        pay_idx = '0;
                    end
                    push_word(w ^ kb, opcode, last, ST_DATA);
                end
                default:
                begin
                    fin    = w[7];
                    opcode = w[3:0];
                    if (opcode != OPC_TEXT && opcode != OPC_BINARY)
                        restart_frame(ST_BAD_OPCODE);
                    else
                        ph = PH_HDR1;
                end
            endcase
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_result_word(result_word_t got);
            result_word_t want;
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("result word %h with none expected", got));
                return;
            end
            want = expected_words.pop_front();
            if (got.data !== want.data)
                report_mismatch($sformatf("payload_byte got %h want %h", got.data, want.data));
            if (got.opcode !== want.opcode)
                report_mismatch($sformatf("frame_opcode got %h want %h",
                                          got.opcode, want.opcode));
            if (got.last !== want.last)
                report_mismatch($sformatf("is_last got %b want %b", got.last, want.last));
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        endtask
    endclass

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte        = 8'd0;
    logic        cfg_write_en   = 1'b0;
    logic [31:0] cfg_write_data = 32'd0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic        is_last;
    logic [2:0]  status;

    deframe_scoreboard sb;
    logic [31:0]       cur_limit   = MAX_PAYLOAD_RESET;
    int                words_sent  = 0;
    int                burst_left  = 0;
    int                stall_left  = 0;
    stall_mode_e       stall_mode  = STALL_NONE;
    int                cycle_count = 0;

    websocket_frame_deframer_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_byte   (payload_byte),
        .frame_opcode   (frame_opcode),
        .is_last        (is_last),
        .status         (status)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_rx_word(rx_byte);
            if (out_valid && !out_stall)
                sb.check_result_word(result_word_t'({payload_byte, frame_opcode, is_last,
                                                     status}));
        end
    end

    // The receiver switches between stall patterns for random stretches of cycles.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            stall_left = $urandom_range(4, 60);
        end
        else
            stall_left--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ~out_stall;
        endcase
    end

    task automatic send_word(input logic [7:0] w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    // Waits until every owed result has come out and the parser has settled.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        settle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        cur_limit = value;
        sb.set_limit(value);
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [63:0] pick_len();
        int          r;
        logic [63:0] len;
        r = $urandom_range(0, 9);
        if (r == 0)
            len = 64'd0;
        else if (r < 7)
            len = 64'($urandom_range(1, 20));
        else if (r < 9)
            len = 64'($urandom_range(120, 140));
        else
            len = (cur_limit <= 32'd300) ? {32'd0, cur_limit} : 64'($urandom_range(1, 8));
        if (len > {32'd0, cur_limit})
            len = {32'd0, cur_limit};
        return len;
    endfunction

    // Sends one header; within the limit, also its mask key and, with FIN, its payload.
    task automatic send_frame(input logic fin, input logic [63:0] len);
        logic      masked;
        logic [3:0] opc;
        logic [6:0] len7;
        len_form_e form;
        int        r;
        masked = ($urandom_range(0, 1) != 0);
        opc = ($urandom_range(0, 1) != 0) ? OPC_TEXT : OPC_BINARY;
        r = $urandom_range(0, 5);
        if (len <= 64'd125)
            form = (r == 0) ? LEN_FORM_16 : ((r == 1) ? LEN_FORM_64 : LEN_FORM_7);
        else if (len <= 64'hFFFF && r < 3)
            form = LEN_FORM_16;
        else
            form = LEN_FORM_64;
        case (form)
            LEN_FORM_7:  len7 = len[6:0];
            LEN_FORM_16: len7 = LEN7_EXT16;
            default:     len7 = LEN7_EXT64;
        endcase
        send_word({fin, 3'($urandom), opc});
        send_word({masked, len7});
        if (form == LEN_FORM_16)
        begin
            send_word(len[15:8]);
            send_word(len[7:0]);
        end
        else if (form == LEN_FORM_64)
        begin
            for (int i = 7; i >= 0; i--)
                send_word(len[8 * i +: 8]);
        end
        if (len <= {32'd0, cur_limit})
        begin
            if (masked)
                repeat (4) send_word(8'($urandom));
            if (fin)
                repeat (int'(len)) send_word(8'($urandom));
        end
    endtask

    task automatic random_frame();
        int          pick;
        logic [7:0]  junk;
        logic [63:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            junk = 8'($urandom);
            if (junk[3:0] == OPC_TEXT || junk[3:0] == OPC_BINARY)
                junk[3:0] = ~junk[3:0];
            send_word(junk);
        end
        else if (pick < 27)
        begin
            // Lengths with upper bits set, or just over the limit, exercise the full 64-bit compare.
            if (cur_limit == 32'hFFFF_FFFF || $urandom_range(0, 3) == 0)
                len = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
            else
                len = {32'd0, cur_limit} + 64'($urandom_range(1, 3));
            send_frame(1'b1, len);
        end
        else if (pick < 37)
            send_frame(1'b0, pick_len());
        else
            send_frame(1'b1, pick_len());
    endtask

    initial
    begin
        logic [7:0]  directed_words [$];
        logic [31:0] limit_steps [$];
        int          phase_end;
        sb = new();
        // Bad opcode with reserved bits set, an empty frame, an unfinished frame,
        // a masked frame with a 16-bit length, one byte over the limit, and the
        // largest 64-bit length.
        directed_words = '{8'h70,
                           8'h81, 8'h00,
                           8'h02, 8'h03,
                           8'hF2, 8'hFE, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A,
                           8'h81, 8'h7E, 8'h04, 8'h01,
                           8'h82, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                           8'hFF, 8'hFF};
        limit_steps = '{32'd1, 32'hFFFF_FFFF, 32'd37, 32'd0, MAX_PAYLOAD_RESET};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed_words[i])
            send_word(directed_words[i]);
        foreach (limit_steps[i])
        begin
            write_limit(limit_steps[i]);
            phase_end = words_sent + RANDOM_WORDS / limit_steps.size();
            while (words_sent < phase_end)
                random_frame();
        end
        settle();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- websocket_frame_deframer_top.f -----
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_front.sv
hw/rtl/wsd_queue.sv
hw/rtl/wsd_back.sv
hw/rtl/websocket_frame_deframer_top.sv
dv/testbench.sv
